/* rtl/bytecode_local_type_scanner_assert.svh */
`ifndef BYTECODE_LOCAL_TYPE_SCANNER_ASSERT_SVH
`define BYTECODE_LOCAL_TYPE_SCANNER_ASSERT_SVH
// assertion macros
`define BLTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BLTS_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* rtl/blts_pkg.sv */
`default_nettype none
package blts_pkg;
   typedef enum logic [3:0] {
      PH_OPCODE, PH_SKIP, PH_INDEX, PH_WOP, PH_WHI, PH_WLO, PH_SWHEAD, PH_SWA, PH_SWB
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUN = 3'd0, ST_PASSED = 3'd1, ST_SLOT = 3'd2, ST_UNKNOWN = 3'd3, ST_END = 3'd4
   } status_type;

   localparam logic [1:0] REG_LOCAL_COUNT = 2'd0;
   localparam logic [1:0] REG_ARG_SLOTS   = 2'd1;
   localparam logic [1:0] REG_STOP_POS    = 2'd2;

   localparam logic [7:0] OP_IINC         = 8'd132;
   localparam logic [7:0] OP_RET          = 8'd169;
   localparam logic [7:0] OP_TABLESWITCH  = 8'd170;
   localparam logic [7:0] OP_LOOKUPSWITCH = 8'd171;
   localparam logic [7:0] OP_WIDE         = 8'd196;

   function automatic logic [2:0] op_len(input logic [7:0] op);
      logic [2:0] r;
      r = 3'd0;
      if (op <= 8'd15) r = 3'd1;
      else if (op == 8'd16 || op == 8'd18) r = 3'd2;
      else if (op == 8'd17 || op == 8'd19 || op == 8'd20) r = 3'd3;
      else if (op <= 8'd25) r = 3'd2;
      else if (op <= 8'd53) r = 3'd1;
      else if (op <= 8'd58) r = 3'd2;
      else if (op <= 8'd131) r = 3'd1;
      else if (op == OP_IINC) r = 3'd3;
      else if (op <= 8'd152) r = 3'd1;
      else if (op <= 8'd168) r = 3'd3;
      else if (op == OP_RET) r = 3'd2;
      else if (op <= 8'd171) r = 3'd0;
      else if (op <= 8'd177) r = 3'd1;
      else if (op <= 8'd184) r = 3'd3;
      else if (op <= 8'd186) r = 3'd5;
      else if (op == 8'd187 || op == 8'd189) r = 3'd3;
      else if (op == 8'd188) r = 3'd2;
      else if (op <= 8'd191) r = 3'd1;
      else if (op <= 8'd193) r = 3'd3;
      else if (op <= 8'd195) r = 3'd1;
      else if (op == OP_WIDE) r = 3'd0;
      else if (op == 8'd197) r = 3'd4;
      else if (op <= 8'd199) r = 3'd3;
      else if (op <= 8'd201) r = 3'd5;
      return r;
   endfunction

   function automatic logic indexed_access(input logic [7:0] op);
      return (op >= 8'd21 && op <= 8'd25) || (op >= 8'd54 && op <= 8'd58);
   endfunction

   function automatic logic [2:0] indexed_type(input logic [7:0] op);
      logic [7:0] d;
      d = (op <= 8'd25) ? op - 8'd21 : op - 8'd54;
      return d[2:0];
   endfunction
endpackage
`default_nettype wire

/* rtl/bytecode_local_type_scanner.sv */
`default_nettype none
`include "bytecode_local_type_scanner_assert.svh"
// Bytecode scanner: one bytecode byte per item, one result item per byte, one item
// per cycle unless stalled. Each item is decoded combinationally from a registered input
// stage into a registered result stage; the decode state (phase, skip counter, switch
// word) updates once per accepted byte. Scanning ends on an out-of-range slot, an
// unknown opcode, an opcode past stop_position or the last byte; later bytes give done.
module bytecode_local_type_scanner (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_code_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_instr_start,
   output logic             rsp_assign_valid,
   output logic [15:0]      rsp_slot,
   output logic [2:0]       rsp_type_code,
   output logic             rsp_done_res,
   output logic [2:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import blts_pkg::*;

   logic [15:0] local_count_ff, arg_slots_ff, stop_pos_ff;
   logic [15:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  op_ff, op_in;
   logic [31:0] skip_ff, skip_in, word_ff, word_in, low_ff, low_in;
   logic [15:0] sidx_ff, sidx_in;
   logic        stopped_ff, stopped_in;
   logic [2:0]  code_ff, code_in;

   logic        iv_ff;
   logic [7:0]  ib_ff;
   logic        il_ff;

   logic        inst, av;
   logic [15:0] sl;
   logic [2:0]  ty;
   logic [2:0]  stop;
   logic        take;
   logic        fire_in;

   logic [15:0] r_slot;
   logic [2:0]  r_type;
   logic        r_do;
   logic [32:0] tb_diff;
   logic [34:0] tb_len;
   logic [31:0] wa;
   logic [7:0]  d8;

   assign csr_ready = 1'b1;
   assign take      = iv_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !iv_ff || take;
   assign fire_in   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_count_ff <= '0;
         arg_slots_ff   <= '0;
         stop_pos_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_LOCAL_COUNT: local_count_ff <= csr_data;
            REG_ARG_SLOTS:   arg_slots_ff   <= csr_data;
            REG_STOP_POS:    stop_pos_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) iv_ff <= 1'b0;
      else if (fire_in) iv_ff <= 1'b1;
      else if (take) iv_ff <= 1'b0;
      if (fire_in) begin
         ib_ff <= req_code_byte;
         il_ff <= req_last_byte;
      end
   end

   always_comb begin
      pos_in = pos_ff + 16'd1; phase_in = phase_ff; op_in = op_ff;
      skip_in = skip_ff; word_in = word_ff; low_in = low_ff; sidx_in = sidx_ff;
      stopped_in = stopped_ff; code_in = code_ff;
      inst = 1'b0; stop = ST_RUN; r_do = 1'b0; r_slot = '0; r_type = '0;
      tb_diff = '0; tb_len = '0; wa = '0; d8 = '0;
      if (stopped_ff) begin
         pos_in = pos_ff;
      end else begin
         unique case (phase_ff)
            PH_OPCODE: begin
               inst = 1'b1;
               if (pos_ff > stop_pos_ff) stop = ST_PASSED;
               else begin
                  op_in = ib_ff;
                  if (ib_ff == OP_WIDE) phase_in = PH_WOP;
                  else if (ib_ff == OP_TABLESWITCH || ib_ff == OP_LOOKUPSWITCH) begin
                     skip_in = {29'd0, 3'd7 - {1'b0, pos_ff[1:0]}};
                     phase_in = PH_SWHEAD;
                  end else if (ib_ff >= 8'd26 && ib_ff <= 8'd45) begin
                     d8 = ib_ff - 8'd26;
                     r_do = 1'b1; r_slot = {14'd0, d8[1:0]}; r_type = d8[4:2];
                  end else if (ib_ff >= 8'd59 && ib_ff <= 8'd78) begin
                     d8 = ib_ff - 8'd59;
                     r_do = 1'b1; r_slot = {14'd0, d8[1:0]}; r_type = d8[4:2];
                  end else if (indexed_access(ib_ff)) phase_in = PH_INDEX;
                  else if (op_len(ib_ff) == 3'd0) stop = ST_UNKNOWN;
                  else if (op_len(ib_ff) != 3'd1) begin
                     skip_in = {29'd0, op_len(ib_ff) - 3'd1};
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 32'd1;
               if (skip_in == '0) phase_in = PH_OPCODE;
            end
            PH_INDEX: begin
               r_do = 1'b1; r_slot = {8'd0, ib_ff}; r_type = indexed_type(op_ff);
               phase_in = PH_OPCODE;
            end
            PH_WOP: begin
               op_in = ib_ff;
               if (indexed_access(ib_ff) || ib_ff == OP_IINC || ib_ff == OP_RET)
                  phase_in = PH_WHI;
               else stop = ST_UNKNOWN;
            end
            PH_WHI: begin
               sidx_in = {ib_ff, 8'd0};
               phase_in = PH_WLO;
            end
            PH_WLO: begin
               sidx_in = {sidx_ff[15:8], ib_ff};
               phase_in = PH_OPCODE;
               if (indexed_access(op_ff)) begin
                  r_do = 1'b1; r_slot = {sidx_ff[15:8], ib_ff}; r_type = indexed_type(op_ff);
               end else if (op_ff == OP_IINC) begin
                  skip_in = 32'd2; phase_in = PH_SKIP;
               end
            end
            PH_SWHEAD: begin
               skip_in = skip_ff - 32'd1;
               if (skip_in == '0) begin
                  skip_in = 32'd4; word_in = '0; phase_in = PH_SWA;
               end
            end
            PH_SWA: begin
               wa = {word_ff[23:0], ib_ff};
               word_in = wa;
               skip_in = skip_ff - 32'd1;
               if (skip_in == '0) begin
                  if (op_ff == OP_LOOKUPSWITCH) begin
                     if (wa[31]) stop = ST_UNKNOWN;
                     else if (wa == '0) phase_in = PH_OPCODE;
                     else begin
                        skip_in = (wa[31:29] != 3'd0) ? 32'hFFFF_FFFF : {wa[28:0], 3'b000};
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     low_in = wa; word_in = '0; skip_in = 32'd4; phase_in = PH_SWB;
                  end
               end
            end
            PH_SWB: begin
               wa = {word_ff[23:0], ib_ff};
               word_in = wa;
               skip_in = skip_ff - 32'd1;
               if (skip_in == '0) begin
                  tb_diff = {1'b0, wa ^ 32'h8000_0000} - {1'b0, low_ff ^ 32'h8000_0000};
                  tb_len = {tb_diff[31:0] + 32'd1 == 32'd0, tb_diff[31:0] + 32'd1, 2'b00};
                  if (tb_diff[32]) stop = ST_UNKNOWN;
                  else begin
                     skip_in = (tb_len[34:32] != 3'd0) ? 32'hFFFF_FFFF : tb_len[31:0];
                     phase_in = PH_SKIP;
                  end
               end
            end
            default: phase_in = PH_OPCODE;
         endcase
         if (r_do && r_slot >= local_count_ff) begin
            stop = ST_SLOT; r_do = 1'b0;
         end
         if (stop == ST_RUN && il_ff) stop = ST_END;
         if (stop != ST_RUN) begin
            stopped_in = 1'b1; code_in = stop;
         end
      end
      av = r_do && (r_slot >= arg_slots_ff);
      sl = av ? r_slot : '0;
      ty = av ? r_type : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; phase_ff <= PH_OPCODE; op_ff <= '0; skip_ff <= '0;
         word_ff <= '0; low_ff <= '0; sidx_ff <= '0; stopped_ff <= 1'b0; code_ff <= ST_RUN;
         rsp_valid <= 1'b0;
      end else begin
         if (take) begin
            pos_ff <= pos_in; phase_ff <= phase_in; op_ff <= op_in; skip_ff <= skip_in;
            word_ff <= word_in; low_ff <= low_in; sidx_ff <= sidx_in;
            stopped_ff <= stopped_in; code_ff <= code_in;
            rsp_valid <= 1'b1;
         end else if (rsp_ready) rsp_valid <= 1'b0;
      end
      if (take) begin
         rsp_instr_start  <= inst;
         rsp_assign_valid <= av;
         rsp_slot         <= sl;
         rsp_type_code    <= ty;
         rsp_done_res     <= stopped_in;
         rsp_status       <= stopped_ff ? code_ff : stop;
      end
   end

   `BLTS_ASSERT(a_av_range, clock, reset, rsp_valid && rsp_assign_valid |-> rsp_type_code <= 3'd4, "bad type")
   `BLTS_ASSERT(a_stop_sticky, clock, reset, stopped_ff |=> stopped_ff, "stop cleared")
   `BLTS_ASSERT(a_done_quiet, clock, reset, rsp_valid && rsp_status != ST_RUN |-> rsp_done_res, "status without done")
endmodule
`default_nettype wire
